FILE: hdl/scope_capture_trigger_macros.svh
// Assertion helpers used by the checker file of this block.
`ifndef SCOPE_CAPTURE_TRIGGER_MACROS_SVH
`define SCOPE_CAPTURE_TRIGGER_MACROS_SVH

// Implication in the same cycle, masked while reset is applied.
`define SCT_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scope_capture_trigger check failed");

// Implication on the following cycle, also checked across reset.
`define SCT_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("scope_capture_trigger check failed");

`endif

FILE: hdl/sct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package sct_pkg;

  // Default structure sizes.
  localparam int DEPTH_LOG2_DEF  = 10;
  localparam int SAMPLE_BITS_DEF = 16;

  // Command queue between the front and the back end.
  localparam int QDEPTH = 2;

  // Fixed field widths.
  localparam int KIND_W   = 2;
  localparam int SMP_W    = 16;
  localparam int COL_W    = 12;
  localparam int OFS_W    = 10;
  localparam int BACK_W   = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  // Command kinds.
  localparam logic [KIND_W-1:0] KIND_CLEAR   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READOUT = 2'd3;

  // Result kinds.
  localparam logic RES_SEARCH = 1'b0;
  localparam logic RES_POINT  = 1'b1;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_ENABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_START  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_WINDOW = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_THRESH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERT_CENTER = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W    = 3'd6;

  // Register reset values.
  localparam logic signed [15:0] THRESH_RST = -16'sd410;
  localparam logic [11:0]        SCREEN_W_RST = 12'd1024;

  typedef struct packed {
    logic [KIND_W-1:0]       kind;
    logic signed [SMP_W-1:0] sample;
    logic [COL_W-1:0]        column;
  } cmd_t;

  typedef struct packed {
    logic                enable;
    logic [9:0]          start;
    logic [9:0]          window;
    logic signed [15:0]  threshold;
    logic [23:0]         gain;
    logic [11:0]         center;
    logic [11:0]         width;
  } cfg_t;

  typedef struct packed {
    logic               result_kind;
    logic [OFS_W-1:0]   trigger_offset;
    logic [11:0]        x_coord;
    logic signed [15:0] y_coord;
  } res_t;

endpackage

`default_nettype wire

FILE: hdl/sct_front.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire sct_pkg::cmd_t in_cmd,
  output logic               busy,
  output logic               q_valid,
  output sct_pkg::cmd_t      q_cmd,
  input  wire logic          q_pop
);
  import sct_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;

  cmd_t              q_mem [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              push;

  // A command is taken whenever the queue has room.
  assign busy    = (cnt_r == CNT_W'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_mem[rd_ptr_r];

  // Occupancy follows pushes and pops.
  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  // Queue pointers and occupancy.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr_r] <= in_cmd;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sct_back.sv
`timescale 1ns / 1ps
`default_nettype none

module sct_back #(
  parameter int DEPTH_LOG2  = sct_pkg::DEPTH_LOG2_DEF,
  parameter int SAMPLE_BITS = sct_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sct_pkg::cfg_t cfg,
  input  wire logic          q_valid,
  input  wire sct_pkg::cmd_t q_cmd,
  output logic               q_pop,
  output logic               res_strobe,
  output sct_pkg::res_t      res
);
  import sct_pkg::*;

  localparam int AW    = DEPTH_LOG2;
  localparam int DEPTH = 1 << AW;
  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = (SB > SMP_W) ? SB : SMP_W;
  localparam int PW    = SB + 25;
  localparam int QW    = PW - 20;
  localparam int YW    = ((QW > 13) ? QW : 13) + 1;
  localparam int SW    = (YW > 17) ? YW : 17;
  localparam int BW    = (AW > BACK_W) ? AW : BACK_W;

  localparam logic signed [SW-1:0] Y_MAX = SW'(32'sd32767);
  localparam logic signed [SW-1:0] Y_MIN = SW'(-32'sd32768);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SRCH = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_MUL  = 3'd3;
  localparam logic [2:0] ST_RND  = 3'd4;

  // Ring index a given number of entries behind the write position.
  function automatic logic [AW-1:0] ring_addr(input logic [AW-1:0] wp,
                                              input logic [BACK_W-1:0] back);
    logic [BW-1:0] diff;
    diff = BW'(wp) - BW'(back);
    return diff[AW-1:0];
  endfunction

  logic [2:0]              state_r;
  logic [2:0]              state_nxt;
  logic [AW-1:0]           wp_r;
  logic [AW:0]             fill_r;
  logic [OFS_W-1:0]        locked_r;
  logic [9:0]              iss_r;
  logic                    rdv_r;
  logic [9:0]              rd_i_r;
  logic signed [CW-1:0]    prev_r;
  logic [SB-1:0]           mem [0:DEPTH-1];
  logic [SB-1:0]           mem_q_r;
  logic                    memv_r;
  logic [COL_W-1:0]        col_r;
  logic signed [PW-1:0]    prod_r;
  logic signed [QW-1:0]    q_r;
  logic                    strobe_r;
  res_t                    res_r;

  logic                    take;
  logic                    we;
  logic [AW-1:0]           waddr;
  logic [SB-1:0]           wdata;
  logic signed [CW-1:0]    smp_ext;
  logic                    rd_en;
  logic [AW-1:0]           rd_addr;
  logic                    rd_written;
  logic signed [CW-1:0]    cur_s;
  logic signed [CW-1:0]    thr_w;
  logic                    hit;
  logic                    last;
  logic                    stop;
  logic                    issue_ok;
  logic                    srch_on;
  logic signed [SB-1:0]    s_sb;
  logic signed [PW-1:0]    prod;
  logic signed [PW-1:0]    rnd;
  logic signed [YW-1:0]    y_w;
  logic signed [SW-1:0]    y_s;
  logic signed [15:0]      y_sat;

  assign take  = (state_r == ST_IDLE) && q_valid;
  assign q_pop = take;

  // Push path: advance first, then store the sign-adjusted sample.
  assign we      = take && (q_cmd.kind == KIND_PUSH);
  assign waddr   = wp_r + AW'(1);
  assign smp_ext = CW'(q_cmd.sample);
  assign wdata   = smp_ext[SB-1:0];

  // Search step compare against the previous value.
  assign cur_s    = memv_r ? CW'($signed(mem_q_r)) : '0;
  assign thr_w    = CW'(cfg.threshold);
  assign hit      = (prev_r <= thr_w) && (cur_s > thr_w);
  assign last     = (rd_i_r == cfg.window - 10'd1);
  assign stop     = rdv_r && (hit || last);
  assign issue_ok = (state_r == ST_SRCH) && (iss_r != cfg.window) && !stop;
  assign srch_on  = cfg.enable && (cfg.window != '0);

  // Ring read address: readout lookup or the next search position.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ring_addr(wp_r, BACK_W'(iss_r) + BACK_W'(cfg.start));
    if (take && (q_cmd.kind == KIND_READOUT)) begin
      rd_en   = 1'b1;
      rd_addr = ring_addr(wp_r, BACK_W'(q_cmd.column) + BACK_W'(locked_r));
    end else if (issue_ok) begin
      rd_en = 1'b1;
    end
  end

  // Entries not written since the last clear read as zero.
  assign rd_written = fill_r[AW] || ((rd_addr != '0) && ({1'b0, rd_addr} <= fill_r));

  // Readout arithmetic.
  assign s_sb  = memv_r ? $signed(mem_q_r) : '0;
  assign prod  = PW'($signed({1'b0, cfg.gain})) * PW'(s_sb);
  assign rnd   = prod_r + $signed({{QW{1'b0}}, {20{prod_r[PW-1]}}});
  assign y_w   = YW'(q_r) + YW'($signed({1'b0, cfg.center}));
  assign y_s   = SW'(y_w);

  always_comb begin
    if (y_s > Y_MAX) begin
      y_sat = 16'sh7FFF;
    end else if (y_s < Y_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y_s[15:0];
    end
  end

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (take && (q_cmd.kind == KIND_SEARCH) && srch_on) begin
          state_nxt = ST_SRCH;
        end else if (take && (q_cmd.kind == KIND_READOUT)) begin
          state_nxt = ST_RD;
        end
      end
      ST_SRCH: begin
        if (stop) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_RD:   state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_RND;
      ST_RND:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer registers and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      wp_r     <= '0;
      fill_r   <= '0;
      locked_r <= '0;
      strobe_r <= 1'b0;
      rdv_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (take) begin
            unique case (q_cmd.kind)
              KIND_CLEAR: begin
                wp_r   <= '0;
                fill_r <= '0;
              end
              KIND_PUSH: begin
                wp_r <= waddr;
                if (!fill_r[AW]) begin
                  fill_r <= fill_r + (AW+1)'(1);
                end
              end
              KIND_SEARCH: begin
                if (srch_on) begin
                  iss_r  <= '0;
                  rdv_r  <= 1'b0;
                  prev_r <= '0;
                end else begin
                  locked_r <= '0;
                  strobe_r <= 1'b1;
                  res_r    <= '{RES_SEARCH, '0, '0, '0};
                end
              end
              KIND_READOUT: begin
                col_r <= q_cmd.column;
              end
              default: ;
            endcase
          end
        end
        ST_SRCH: begin
          rdv_r  <= issue_ok;
          rd_i_r <= iss_r;
          if (issue_ok) begin
            iss_r <= iss_r + 10'd1;
          end
          if (stop) begin
            locked_r <= hit ? rd_i_r : '0;
            strobe_r <= 1'b1;
            res_r    <= '{RES_SEARCH, (hit ? rd_i_r : '0), '0, '0};
          end else if (rdv_r) begin
            prev_r <= cur_s;
          end
        end
        ST_RD: begin
          prod_r <= prod;
        end
        ST_MUL: begin
          q_r <= rnd[PW-1:20];
        end
        ST_RND: begin
          strobe_r <= 1'b1;
          res_r    <= '{RES_POINT, locked_r, cfg.width - col_r, y_sat};
        end
        default: ;
      endcase
    end
  end

  // Sample ring: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
      memv_r  <= rd_written;
    end
  end

  assign res_strobe = strobe_r;
  assign res        = res_r;

endmodule

`default_nettype wire

FILE: hdl/scope_capture_trigger.sv
`timescale 1ns / 1ps
`default_nettype none

// Scope capture engine with a rising-crossing trigger over a sample ring.
// Commands are taken on start while busy is low and wait in a two-entry
// queue; busy rises only when that queue is full. The back end runs one
// command at a time: clear and sample push are done as they leave the
// queue, a column readout delivers its point after the ring read, multiply,
// rounding, and offset and saturation steps, and a trigger search walks the
// ring position by position through its single read port before it
// answers. A disabled search answers in the cycle after it leaves the queue.
// The ring is never swept: a fill count since the last clear marks which
// entries hold samples, so neither reset nor clear costs extra cycles.
// Each result is shown for exactly one cycle with out_strobe high and the
// receiver cannot stall it. Configuration writes are always ready and must
// only be made while no command is outstanding.
module scope_capture_trigger #(
  parameter int DEPTH_LOG2  = sct_pkg::DEPTH_LOG2_DEF,
  parameter int SAMPLE_BITS = sct_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [sct_pkg::KIND_W-1:0]        in_kind,
  input  wire logic signed [sct_pkg::SMP_W-1:0]  in_sample,
  input  wire logic [sct_pkg::COL_W-1:0]         in_column,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sct_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [sct_pkg::CFG_DAT_W-1:0]     cfg_data,
  output logic                                   out_strobe,
  output logic                                   out_result_kind,
  output logic [sct_pkg::OFS_W-1:0]              out_trigger_offset,
  output logic [11:0]                            out_x_coord,
  output logic signed [15:0]                     out_y_coord
);
  import sct_pkg::*;

  cfg_t  cfg_r;
  cmd_t  in_cmd;
  cmd_t  q_cmd;
  logic  q_valid;
  logic  q_pop;
  logic  res_strobe;
  res_t  res;

  assign cfg_ready = 1'b1;

  // Configuration register writes; unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{1'b0, '0, '0, THRESH_RST, '0, '0, SCREEN_W_RST};
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_TRIG_ENABLE: cfg_r.enable    <= cfg_data[0];
        REG_TRIG_START:  cfg_r.start     <= cfg_data[9:0];
        REG_TRIG_WINDOW: cfg_r.window    <= cfg_data[9:0];
        REG_TRIG_THRESH: cfg_r.threshold <= $signed(cfg_data[15:0]);
        REG_VERT_GAIN:   cfg_r.gain      <= cfg_data[23:0];
        REG_VERT_CENTER: cfg_r.center    <= cfg_data[11:0];
        REG_SCREEN_W:    cfg_r.width     <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  assign in_cmd = '{in_kind, in_sample, in_column};

  // Command intake and queue.
  sct_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_cmd  (in_cmd),
    .busy    (busy),
    .q_valid (q_valid),
    .q_cmd   (q_cmd),
    .q_pop   (q_pop)
  );

  // Ring, trigger search and readout datapath.
  sct_back #(
    .DEPTH_LOG2  (DEPTH_LOG2),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_valid    (q_valid),
    .q_cmd      (q_cmd),
    .q_pop      (q_pop),
    .res_strobe (res_strobe),
    .res        (res)
  );

  assign out_strobe         = res_strobe;
  assign out_result_kind    = res.result_kind;
  assign out_trigger_offset = res.trigger_offset;
  assign out_x_coord        = res.x_coord;
  assign out_y_coord        = res.y_coord;

endmodule

`default_nettype wire

FILE: hdl/sct_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "scope_capture_trigger_macros.svh"

module sct_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic                          busy,
  input  wire logic [sct_pkg::KIND_W-1:0]    in_kind,
  input  wire logic                          out_strobe,
  input  wire logic                          out_result_kind,
  input  wire logic [sct_pkg::OFS_W-1:0]     out_trigger_offset,
  input  wire logic [11:0]                   out_x_coord,
  input  wire logic signed [15:0]            out_y_coord
);
  import sct_pkg::*;

  logic [3:0]       pending_r;
  logic [OFS_W-1:0] last_ofs_r;
  logic             asks;

  // Accepted commands that owe a result.
  assign asks = start && !busy && ((in_kind == KIND_SEARCH) || (in_kind == KIND_READOUT));

  // Track owed results and the most recent search answer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r  <= '0;
      last_ofs_r <= '0;
    end else begin
      pending_r <= pending_r + 4'(asks) - 4'(out_strobe);
      if (out_strobe && (out_result_kind == RES_SEARCH)) begin
        last_ofs_r <= out_trigger_offset;
      end
    end
  end

  // A result is only shown when a command owes one.
  `SCT_ASSERT_IMPL(a_no_spurious_result, out_strobe, pending_r != 4'd0)

  // Search answers carry no screen coordinates.
  `SCT_ASSERT_IMPL(a_search_zero_xy, out_strobe && (out_result_kind == RES_SEARCH), (out_x_coord == 12'd0) && (out_y_coord == 16'sd0))

  // Points use the offset locked by the latest search.
  `SCT_ASSERT_IMPL(a_point_offset, out_strobe && (out_result_kind == RES_POINT), out_trigger_offset == last_ofs_r)

  // Reset leaves the queue empty and no result on the port.
  `SCT_ASSERT_NEXT(a_reset_quiet, !rst_n, !busy && !out_strobe)

endmodule

bind scope_capture_trigger sct_checker u_sct_checker (.*);

`default_nettype wire
